FILE: design/binary_min_heap_queue_top_defines.svh
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top_defines.svh
// Assertion macros shared by the heap queue checker.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define BMHQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("heap queue check failed");

// Next-cycle implication, quiet while reset is asserted.
`define BMHQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("heap queue check failed");

`endif

FILE: design/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Types and codes shared by the heap queue controller, datapath and top.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

	localparam int KEY_W  = 32;
	localparam int CNT_W  = 32;
	localparam int HELD_W = 8;

	localparam logic REQ_INSERT  = 1'b0;
	localparam logic REQ_EXTRACT = 1'b1;

	typedef logic signed [KEY_W-1:0] key_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic up;
		logic ext_ld;
		logic down;
		logic load_out;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic up_done;
		logic down_done;
	} dp_status_t;

	typedef struct packed {
		key_t              min_key;
		logic              key_valid;
		logic              insert_dropped;
		logic [HELD_W-1:0] entries_held;
		logic [CNT_W-1:0]  sift_visits;
	} result_t;

endpackage

`default_nettype wire

FILE: design/bmhq_req_if.sv
// ----------------------------------------------------------------------------
// bmhq_req_if
// Request channel: valid/ready handshake carrying one heap request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmhq_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [31:0] key_in;

	modport source (output valid, output req_type, output key_in, input ready);
	modport sink   (input valid, input req_type, input key_in, output ready);
endinterface

`default_nettype wire

FILE: design/bmhq_rsp_if.sv
// ----------------------------------------------------------------------------
// bmhq_rsp_if
// Response channel: valid/ready handshake carrying one heap result.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmhq_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] min_key;
	logic               key_valid;
	logic               insert_dropped;
	logic [7:0]         entries_held;
	logic [31:0]        sift_visits;

	modport source (output valid, output min_key, output key_valid, output insert_dropped,
		output entries_held, output sift_visits, input ready);
	modport sink   (input valid, input min_key, input key_valid, input insert_dropped,
		input entries_held, input sift_visits, output ready);
endinterface

`default_nettype wire

FILE: design/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for one heap request: sift-up or sift-down loop if needed, then result.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_req_type,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output bmhq_pkg::dp_cmd_t         cmd,
	input  wire bmhq_pkg::dp_status_t status
);
	import bmhq_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_UP     = 5'b00010,
		ST_EXT_LD = 5'b00100,
		ST_DOWN   = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   load;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign load      = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.accept   = accept;
		cmd.up       = (state_q == ST_UP);
		cmd.ext_ld   = (state_q == ST_EXT_LD);
		cmd.down     = (state_q == ST_DOWN);
		cmd.load_out = load;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_req_type == REQ_EXTRACT) begin
						state_d = status.empty ? ST_FIN : ST_EXT_LD;
					end else begin
						state_d = status.full ? ST_FIN : ST_UP;
					end
				end
			end
			ST_UP: begin
				if (status.up_done) state_d = ST_FIN;
			end
			ST_EXT_LD: begin
				// the last key just left: nothing to sift
				state_d = status.empty ? ST_FIN : ST_DOWN;
			end
			ST_DOWN: begin
				if (status.down_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/bmhq_datapath.sv
// ----------------------------------------------------------------------------
// bmhq_datapath
// Key store, fill count, moving key, node index, visit counter and result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_datapath #(
	parameter int CAPACITY = 255
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bmhq_pkg::dp_cmd_t    cmd,
	output bmhq_pkg::dp_status_t      status,
	input  wire logic                 in_req_type,
	input  wire bmhq_pkg::key_t       in_key,
	output bmhq_pkg::result_t         result
);
	import bmhq_pkg::*;

	localparam int FW = $clog2(CAPACITY + 1);
	localparam int CW = FW + 1;

	// heap positions 1..CAPACITY, position 0 unused
	key_t              key_store_q [CAPACITY+1];

	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     idx_q;
	key_t              key_q;
	key_t              min_q;
	logic              valid_q;
	logic              drop_q;
	logic [CNT_W-1:0]  visits_q;
	key_t              rda_q;
	key_t              rdb_q;
	result_t           out_q;

	logic [FW-1:0]     addr_a, addr_b, wr_addr, new_idx, par_idx;
	key_t              wr_data, best_val, child_val;
	logic              wr_en;
	logic [CW-1:0]     fill_ext, lc, rc, best_idx, bl, br;
	logic              l_in, r_in, a_lt, b_lt, parent_lt, up_done, down_done;
	logic [FW+HELD_W-1:0] held_wide;

	assign fill_ext  = {1'b0, fill_q};
	assign lc        = {idx_q, 1'b0};
	assign rc        = {idx_q, 1'b1};
	assign l_in      = (lc <= fill_ext);
	assign r_in      = (rc <= fill_ext);
	assign new_idx   = fill_q + FW'(1);
	assign par_idx   = idx_q >> 1;

	// sift-down: smallest of node, left child, right child; ties keep the node
	assign a_lt      = l_in && (rda_q < key_q);
	assign best_val  = a_lt ? rda_q : key_q;
	assign b_lt      = r_in && (rdb_q < best_val);
	assign down_done = !a_lt && !b_lt;
	assign best_idx  = b_lt ? rc : lc;
	assign child_val = b_lt ? rdb_q : rda_q;
	assign bl        = {best_idx[FW-1:0], 1'b0};
	assign br        = {best_idx[FW-1:0], 1'b1};

	// sift-up: move only while the parent is strictly greater
	assign parent_lt = (key_q < rda_q);
	assign up_done   = (idx_q == FW'(1)) || !parent_lt;

	always_comb begin
		addr_a  = '0;
		addr_b  = '0;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = key_q;
		if (cmd.accept) begin
			if (in_req_type == REQ_INSERT) begin
				addr_a = new_idx >> 1;
			end else begin
				addr_a = FW'(1);
				addr_b = fill_q;
			end
		end
		if (cmd.up) begin
			wr_en = 1'b1;
			if (!up_done) begin
				wr_data = rda_q;
				addr_a  = par_idx >> 1;
			end
		end
		if (cmd.ext_ld) begin
			// idx is the root here; fetch its children
			addr_a = l_in ? lc[FW-1:0] : '0;
			addr_b = r_in ? rc[FW-1:0] : '0;
		end
		if (cmd.down) begin
			wr_en = 1'b1;
			if (!down_done) begin
				wr_data = child_val;
				addr_a  = (bl <= fill_ext) ? bl[FW-1:0] : '0;
				addr_b  = (br <= fill_ext) ? br[FW-1:0] : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) key_store_q[wr_addr] <= wr_data;
		rda_q <= key_store_q[addr_a];
		rdb_q <= key_store_q[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			visits_q <= '0;
			valid_q  <= 1'b0;
			drop_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				valid_q <= 1'b0;
				drop_q  <= 1'b0;
				if (in_req_type == REQ_INSERT) begin
					if (fill_q == FW'(CAPACITY)) begin
						drop_q <= 1'b1;
					end else begin
						fill_q <= new_idx;
					end
				end else if (fill_q != '0) begin
					fill_q  <= fill_q - FW'(1);
					valid_q <= 1'b1;
				end
			end
			if (cmd.down) visits_q <= visits_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			min_q <= '0;
			key_q <= in_key;
			idx_q <= (in_req_type == REQ_INSERT) ? new_idx : FW'(1);
		end
		if (cmd.ext_ld) begin
			min_q <= rda_q;
			key_q <= rdb_q;
		end
		if (cmd.up && !up_done) idx_q <= par_idx;
		if (cmd.down && !down_done) idx_q <= best_idx[FW-1:0];
		if (cmd.load_out) begin
			out_q.min_key        <= min_q;
			out_q.key_valid      <= valid_q;
			out_q.insert_dropped <= drop_q;
			out_q.entries_held   <= held_wide[HELD_W-1:0];
			out_q.sift_visits    <= visits_q;
		end
	end

	assign held_wide = {{HELD_W{1'b0}}, fill_q};

	always_comb begin
		status           = '0;
		status.full      = (fill_q == FW'(CAPACITY));
		status.empty     = (fill_q == '0);
		status.up_done   = up_done;
		status.down_done = down_done;
	end

	assign result = out_q;

endmodule

`default_nettype wire

FILE: design/binary_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top
// Binary min-heap priority queue of signed 32-bit keys with insert and
// extract-minimum requests, one result beat per request beat.
//
//   channel | dir | handshake       | payload
//   --------+-----+-----------------+--------------------------------------------
//   req     | in  | valid / ready   | req_type, key_in
//   rsp     | out | valid / ready   | min_key, key_valid, insert_dropped,
//           |     |                 | entries_held, sift_visits
//
// An insert sifts its key up through L levels, L the number of levels it climbs; an
// extract sifts the last key down from the root in V visits (at most log2(CAPACITY)+1).
// Drops and empty extracts go straight to the result with no sift. One level per cycle:
// the key store reads both children (or the parent) through its registered read ports.
// Reset clears the fill count and visit counter; the key store keeps no reset.
// A stalled rsp beat holds in the result register while the next req is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap_queue_top #(
	parameter int CAPACITY = 255
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bmhq_req_if.sink   req,
	bmhq_rsp_if.source rsp
);
	import bmhq_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	result_t    result;

	// sequence the request: accept, walk the tree, hand over the result
	bmhq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (req.ready),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.cmd         (cmd),
		.status      (status)
	);

	// hold the keys, move the sifting key, count visits
	bmhq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_req_type (req.req_type),
		.in_key      (req.key_in),
		.result      (result)
	);

	// drive the rsp beat from the result register
	assign rsp.min_key        = result.min_key;
	assign rsp.key_valid      = result.key_valid;
	assign rsp.insert_dropped = result.insert_dropped;
	assign rsp.entries_held   = result.entries_held;
	assign rsp.sift_visits    = result.sift_visits;

endmodule

`default_nettype wire

FILE: design/bmhq_checker.sv
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks on the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_min_heap_queue_top_defines.svh"

module bmhq_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_ready,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire logic signed [31:0] min_key,
	input wire logic               key_valid,
	input wire logic               insert_dropped,
	input wire logic [7:0]         entries_held,
	input wire logic [31:0]        sift_visits
);

	// a stalled rsp beat holds
	`BMHQ_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(min_key) && $stable(key_valid) && $stable(insert_dropped) && $stable(entries_held) && $stable(sift_visits))

	// a request keeps the block busy for at least the next cycle
	`BMHQ_ASSERT_NXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready)

	// an extract result and a dropped insert never coincide
	`BMHQ_ASSERT_IMP(a_flags_excl, clk, arst_n, rsp_valid, !(key_valid && insert_dropped))

	// no key extracted means a zero key
	`BMHQ_ASSERT_IMP(a_zero_key, clk, arst_n, rsp_valid && !key_valid, min_key == 32'sd0)

endmodule

bind binary_min_heap_queue_top bmhq_checker u_bmhq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.min_key        (rsp.min_key),
	.key_valid      (rsp.key_valid),
	.insert_dropped (rsp.insert_dropped),
	.entries_held   (rsp.entries_held),
	.sift_visits    (rsp.sift_visits)
);

`default_nettype wire
